### rtl/u8splice_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 validating string splice block.
// Holds byte class constants, register indexes and channel widths; no dependencies.
package u8splice_pkg;

    // Channel widths
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 1;
    localparam int CHAR_W      = 17;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Character counter saturation value
    localparam logic [CHAR_W-1:0] CHAR_MAX_COUNT = 17'h1FFFF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_START_POSITION = 1'b0,
        REG_SPAN_LENGTH    = 1'b1
    } cfg_reg_t;

    // Selector carried in s_tuser
    typedef enum logic [0:0] {
        OP_VALUE       = 1'b0,
        OP_REPLACEMENT = 1'b1
    } op_t;

    // Byte class limits
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] LEAD_SURR   = 8'hED;
    // Second byte limits for the overlong, surrogate and range rules
    localparam logic [7:0] E0_MIN      = 8'hA0;
    localparam logic [7:0] ED_MAX      = 8'h9F;
    localparam logic [7:0] F0_MIN      = 8'h90;
    localparam logic [7:0] F4_MAX      = 8'h8F;

endpackage

### rtl/utf8_validating_string_splice_top.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 validating string splice block.
// Depends on u8splice_pkg.
//
// Takes one byte per cycle, back to back, while m_tready is high, and returns
// one marked byte per input byte in the next cycle. Decode, validation and span
// compare sit between the input handshake and a single output register;
// s_tready is high whenever that register is empty or being emptied, so the
// sustained rate is one item per clock while m_tready stays high. Value bytes
// (s_tuser = 0) are marked kept, dropped or insert-before; replacement bytes
// (s_tuser = 1) are always kept. bad_utf8 is meaningful only on items with
// m_tlast set; a job that reports it must be discarded. Configuration writes
// must only be made while no item is in flight; the block does not hold them off.
module utf8_validating_string_splice_top
    import u8splice_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [0] op
    input  logic                  s_tlast,   // last
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] out_byte, [24:8] char_index, [31:25] zero
    output logic [M_TUSER_W-1:0]  m_tuser,   // [0] keep, [1] insert_before, [2] bad_utf8
    output logic                  m_tlast    // string_done
);

    // Configuration: start position kept as zero-based position plus a flag
    logic [CFG_DATA_W-1:0] pos_reg, pos_next;
    logic                  pos_ok_reg, pos_ok_next;
    logic [CFG_DATA_W-1:0] span_reg, span_next;

    // Decode state
    logic [1:0]        pending_reg, pending_next;
    logic [7:0]        lead_reg, lead_next;
    logic [1:0]        tailpos_reg, tailpos_next;
    logic [CHAR_W-1:0] count_reg, count_next;
    logic              err_reg, err_next;

    // Output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic       accept;
    logic [7:0] b;
    logic       is_lead;
    logic       advance;
    logic       done_bad;
    logic       before_start;
    logic       before_end;
    logic       in_span;
    logic       insert_pt;
    logic [CFG_DATA_W:0] span_end;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign is_lead  = (pending_reg == 2'd0);

    // Configuration writes
    always_comb begin
        pos_next    = pos_reg;
        pos_ok_next = pos_ok_reg;
        span_next   = span_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_START_POSITION: begin
                    pos_next    = cfg_wdata - CFG_DATA_W'(1);
                    pos_ok_next = !cfg_wdata[CFG_DATA_W-1] && (cfg_wdata != '0);
                end
                REG_SPAN_LENGTH: span_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // UTF-8 decode and validation
    always_comb begin
        pending_next = pending_reg;
        lead_next    = lead_reg;
        tailpos_next = tailpos_reg;
        err_next     = err_reg;
        advance      = 1'b0;
        if (is_lead) begin
            if (!b[7]) begin
                advance = 1'b1;
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                pending_next = 2'd1;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                pending_next = 2'd2;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                pending_next = 2'd3;
            end else begin
                advance  = 1'b1;
                err_next = 1'b1;
            end
            if (!advance) begin
                lead_next    = b;
                tailpos_next = 2'd0;
            end
        end else begin
            if ((b & CONT_MASK) != CONT_TAG) err_next = 1'b1;
            // second byte range rules
            if (tailpos_reg == 2'd0) begin
                if (lead_reg == LEAD3_LO  && b < E0_MIN) err_next = 1'b1;
                if (lead_reg == LEAD_SURR && b > ED_MAX) err_next = 1'b1;
                if (lead_reg == LEAD4_LO  && b < F0_MIN) err_next = 1'b1;
                if (lead_reg == LEAD4_HI  && b > F4_MAX) err_next = 1'b1;
            end
            tailpos_next = tailpos_reg + 2'd1;
            pending_next = pending_reg - 2'd1;
            advance      = (pending_reg == 2'd1);
        end

        count_next = count_reg;
        if (advance && count_reg != CHAR_MAX_COUNT) count_next = count_reg + CHAR_W'(1);

        // end of string: truncation check, then clear
        done_bad = 1'b0;
        if (s_tlast) begin
            if (pending_next != 2'd0) err_next = 1'b1;
            done_bad     = err_next;
            pending_next = 2'd0;
            lead_next    = 8'd0;
            tailpos_next = 2'd0;
            count_next   = '0;
            err_next     = 1'b0;
        end
    end

    // Span compare against the current character index
    always_comb begin
        span_end     = {1'b0, pos_reg} + {1'b0, span_reg};
        before_start = (pos_reg[CFG_DATA_W-1:CHAR_W] != '0) || (count_reg < pos_reg[CHAR_W-1:0]);
        before_end   = (span_end[CFG_DATA_W:CHAR_W] != '0) || (count_reg < span_end[CHAR_W-1:0]);
        in_span      = pos_ok_reg && !before_start && (span_reg[CFG_DATA_W-1] || before_end);
        insert_pt    = pos_ok_reg && is_lead && (pos_reg[CFG_DATA_W-1:CHAR_W] == '0)
                       && (count_reg == pos_reg[CHAR_W-1:0]);
    end

    // Result register load
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tready) m_tvalid_next = 1'b0;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {(M_TDATA_W-CHAR_W-8)'(0), count_reg, b};
            m_tlast_next  = s_tlast;
            if (op_t'(s_tuser[0]) == OP_VALUE) begin
                m_tuser_next = {done_bad, insert_pt, !in_span};
            end else begin
                m_tuser_next = {done_bad, 1'b0, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            pos_ok_reg   <= 1'b1;
            span_reg     <= '0;
            pending_reg  <= 2'd0;
            lead_reg     <= 8'd0;
            tailpos_reg  <= 2'd0;
            count_reg    <= '0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            pos_ok_reg   <= pos_ok_next;
            span_reg     <= span_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                pending_reg <= pending_next;
                lead_reg    <= lead_next;
                tailpos_reg <= tailpos_next;
                count_reg   <= count_next;
                err_reg     <= err_next;
            end
        end
    end

    // Payload holds no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/u8splice_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the UTF-8 validating string splice block, with its bind.
// Depends on u8splice_pkg and utf8_validating_string_splice_top.
module u8splice_checker
    import u8splice_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    // Set once a string has ended at the output, until the next item leaves
    logic after_last_reg, after_last_next;

    always_comb begin
        after_last_next = after_last_reg;
        if (m_tvalid && m_tready) after_last_next = m_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_last_reg <= 1'b1;
        end else begin
            after_last_reg <= after_last_next;
        end
    end

    // A stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Every accepted byte gives a result in the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // bad_utf8 only at the end of a string
    a_bad_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !m_tuser[2])
        else $error("bad_utf8 set before end of string");

    // First item of a string has character index zero
    a_first_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && after_last_reg |-> m_tdata[CHAR_W+7:8] == '0)
        else $error("string did not start at character zero");

    // Nothing pending after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_validating_string_splice_top u8splice_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/utf8_validating_string_splice_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_validating_string_splice_top: streams value and
// replacement byte strings, predicts every marked byte and compares it field by field.
// Depends on u8splice_pkg and the RTL of the block; needs no files or arguments.
module utf8_validating_string_splice_top_tb;
    import u8splice_pkg::*;

    // Expected marks for one byte
    typedef struct packed {
        logic [7:0]        data;
        logic              keep;
        logic              ins_before;
        logic [CHAR_W-1:0] char_idx;
        logic              done;
        logic              bad;
    } mark_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [0:0]            cfg_index = REG_START_POSITION;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] data_byte
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // [0] op
    logic                  s_tlast   = 1'b0; // last
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [7:0] out_byte, [24:8] char_index, [31:25] zero
    logic [M_TUSER_W-1:0]  m_tuser;          // [0] keep, [1] insert_before, [2] bad_utf8
    logic                  m_tlast;          // string_done

    // Register copies and decoder state of the predictor
    logic signed [63:0] cfg_start = 64'sd1;
    logic signed [63:0] cfg_span  = 64'sd0;
    logic [1:0]         u8_pending = '0;
    logic [7:0]         u8_lead    = '0;
    logic [1:0]         u8_tailpos = '0;
    logic [CHAR_W-1:0]  u8_chars   = '0;
    logic               u8_bad     = 1'b0;

    mark_t       pending_marks[$];
    logic [7:0]  str_buf[$];
    int          mismatch_cnt   = 0;
    int          items_sent     = 0;
    int          src_gap_pct    = 0;
    int          sink_stall_pct = 0;
    logic        hold_rx        = 1'b0;

    utf8_validating_string_splice_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("utf8_validating_string_splice_top_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= 40)
            $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    endtask

    // Decode one byte, update the UTF-8 state and work out its marks
    function automatic mark_t predict_mark(input op_t op, input logic [7:0] b,
                                           input logic last);
        mark_t       r;
        logic [63:0] c64;
        logic [63:0] p;
        logic        lead_now;
        r.char_idx = u8_chars;
        c64 = {{(64 - CHAR_W){1'b0}}, u8_chars};
        lead_now = (u8_pending == 0);
        if (lead_now) begin
            if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                u8_pending = 2'd1;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                u8_pending = 2'd2;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                u8_pending = 2'd3;
            end else if (b[7]) begin
                // stray continuation or never-valid lead: one-byte character
                u8_bad = 1'b1;
            end
            u8_lead    = b;
            u8_tailpos = '0;
            if (u8_pending == 0 && u8_chars != CHAR_MAX_COUNT)
                u8_chars++;
        end else begin
            if ((b & CONT_MASK) != CONT_TAG)
                u8_bad = 1'b1;
            // overlong, surrogate and range rules look at the second byte only
            if (u8_tailpos == 0) begin
                if (u8_lead == LEAD3_LO  && b < E0_MIN) u8_bad = 1'b1;
                if (u8_lead == LEAD_SURR && b > ED_MAX) u8_bad = 1'b1;
                if (u8_lead == LEAD4_LO  && b < F0_MIN) u8_bad = 1'b1;
                if (u8_lead == LEAD4_HI  && b > F4_MAX) u8_bad = 1'b1;
            end
            u8_tailpos++;
            u8_pending--;
            if (u8_pending == 0 && u8_chars != CHAR_MAX_COUNT)
                u8_chars++;
        end
        r.data = b;
        r.done = last;
        r.bad  = 1'b0;
        if (last) begin
            r.bad = u8_bad | (u8_pending != 0);
            u8_pending = '0;
            u8_lead    = '0;
            u8_tailpos = '0;
            u8_chars   = '0;
            u8_bad     = 1'b0;
        end
        // span marks apply to value bytes only
        r.keep       = 1'b1;
        r.ins_before = 1'b0;
        if (op == OP_VALUE && cfg_start > 0) begin
            p = $unsigned(cfg_start) - 64'd1;
            r.ins_before = lead_now && (c64 == p);
            if (c64 >= p)
                r.keep = (cfg_span < 0) ? 1'b0 : !((c64 - p) < $unsigned(cfg_span));
        end
        return r;
    endfunction

    // Result checking and prediction at each accepted item
    always @(posedge aclk) begin : score
        mark_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_marks.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata, 32'd0);
                end else begin
                    want = pending_marks.pop_front();
                    if (m_tdata[7:0] != want.data)
                        report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.data));
                    if (m_tdata[24:8] != want.char_idx)
                        report_mismatch("char_index", 32'(m_tdata[24:8]),
                                        32'(want.char_idx));
                    if (m_tdata[31:25] != '0)
                        report_mismatch("tdata pad", 32'(m_tdata[31:25]), 32'd0);
                    if (m_tuser[0] != want.keep)
                        report_mismatch("keep", 32'(m_tuser[0]), 32'(want.keep));
                    if (m_tuser[1] != want.ins_before)
                        report_mismatch("insert_before", 32'(m_tuser[1]),
                                        32'(want.ins_before));
                    if (m_tuser[2] != want.bad)
                        report_mismatch("bad_utf8", 32'(m_tuser[2]), 32'(want.bad));
                    if (m_tlast != want.done)
                        report_mismatch("string_done", 32'(m_tlast), 32'(want.done));
                end
            end
            if (s_tvalid && s_tready)
                pending_marks.push_back(predict_mark(op_t'(s_tuser), s_tdata, s_tlast));
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        m_tready <= !hold_rx && ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_byte(input op_t op, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Sends str_buf as one string; an unclosed string runs on into the next bytes
    task automatic send_string(input op_t op, input logic close);
        for (int k = 0; k < str_buf.size(); k++)
            send_byte(op, str_buf[k], close && (k == str_buf.size() - 1));
        str_buf.delete();
    endtask

    // Drops s_tvalid and waits first so the last accepted item is already queued
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_marks.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Both registers back to back; only called with the block idle
    task automatic program_splice(input logic [63:0] start, input logic [63:0] span);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START_POSITION;
        cfg_wdata <= start;
        @(posedge aclk);
        cfg_index <= REG_SPAN_LENGTH;
        cfg_wdata <= span;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_start = start;
        cfg_span  = span;
    endtask

    // Appends one well-formed character, leaning toward the range edges
    function automatic void add_char();
        logic [7:0] lead;
        logic [7:0] second;
        case ($urandom_range(3))
            0: str_buf.push_back(8'($urandom_range(127, 0)));
            1: begin
                lead = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
                str_buf.push_back(lead);
                str_buf.push_back(CONT_TAG + 8'($urandom_range(63)));
            end
            2: begin
                lead = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
                if ($urandom_range(2) == 0)
                    lead = $urandom_range(1) ? LEAD3_LO : LEAD_SURR;
                if (lead == LEAD3_LO)
                    second = 8'($urandom_range(8'hBF, E0_MIN));
                else if (lead == LEAD_SURR)
                    second = 8'($urandom_range(ED_MAX, CONT_TAG));
                else
                    second = CONT_TAG + 8'($urandom_range(63));
                str_buf.push_back(lead);
                str_buf.push_back(second);
                str_buf.push_back(CONT_TAG + 8'($urandom_range(63)));
            end
            default: begin
                lead = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
                if (lead == LEAD4_LO)
                    second = 8'($urandom_range(8'hBF, F0_MIN));
                else if (lead == LEAD4_HI)
                    second = 8'($urandom_range(F4_MAX, CONT_TAG));
                else
                    second = CONT_TAG + 8'($urandom_range(63));
                str_buf.push_back(lead);
                str_buf.push_back(second);
                str_buf.push_back(CONT_TAG + 8'($urandom_range(63)));
                str_buf.push_back(CONT_TAG + 8'($urandom_range(63)));
            end
        endcase
    endfunction

    // Breaks str_buf: random byte, cut tail, stray byte or dropped byte
    function automatic void spoil_string();
        int         pos;
        logic [7:0] stray;
        pos = $urandom_range(str_buf.size() - 1);
        case ($urandom_range(3))
            0: str_buf[pos] = 8'($urandom_range(255));
            1: if (str_buf.size() > 1) void'(str_buf.pop_back());
            2: begin
                case ($urandom_range(2))
                    0: stray = CONT_TAG + 8'($urandom_range(63));
                    1: stray = 8'hC0 + 8'($urandom_range(1));
                    default: stray = 8'hF5 + 8'($urandom_range(10));
                endcase
                str_buf.insert(pos, stray);
            end
            default: if (str_buf.size() > 1) str_buf.delete(pos);
        endcase
    endfunction

    // One job: a value string, then a replacement string
    task automatic run_job(input logic spoil);
        int n;
        n = $urandom_range(10, 1);
        repeat (n) add_char();
        if (spoil && $urandom_range(1)) spoil_string();
        send_string(OP_VALUE, !(spoil && $urandom_range(3) == 0));
        n = $urandom_range(4, 1);
        repeat (n) add_char();
        if (spoil && $urandom_range(1)) spoil_string();
        send_string(OP_REPLACEMENT, 1'b1);
    endtask

    function automatic logic [63:0] pick_start();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7FFF_FFFF_FFFF_FFFF;
            3: return 64'd0;
            default: return 64'($urandom_range(14, 1));
        endcase
    endfunction

    function automatic logic [63:0] pick_span();
        case ($urandom_range(7))
            0: return {$urandom, $urandom};
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7FFF_FFFF_FFFF_FFFF;
            3: return '1;
            4: return 64'd0;
            default: return 64'($urandom_range(6, 1));
        endcase
    endfunction

    // Every character width with its edge values, plus a replacement string
    task automatic test_valid_chars();
        program_splice(64'd2, 64'd2);
        str_buf = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
                    8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F};
        send_string(OP_VALUE, 1'b1);
        str_buf = '{8'hF0, 8'h90, 8'h80, 8'h80};
        send_string(OP_REPLACEMENT, 1'b1);
    endtask

    // Invalid leads, overlong, surrogate, bad continuation, truncation, op switch
    task automatic test_malformed();
        str_buf = '{8'h80};
        send_string(OP_VALUE, 1'b1);
        str_buf = '{8'hFF};
        send_string(OP_REPLACEMENT, 1'b1);
        str_buf = '{8'hE0, 8'h9F, 8'h80};
        send_string(OP_VALUE, 1'b1);
        str_buf = '{8'hED, 8'hA0, 8'h80};
        send_string(OP_VALUE, 1'b1);
        str_buf = '{8'hC2, 8'h41};
        send_string(OP_VALUE, 1'b1);
        str_buf = '{8'hE2, 8'h82};
        send_string(OP_VALUE, 1'b1);
        // value string left open, finished by replacement bytes
        str_buf = '{8'hE2};
        send_string(OP_VALUE, 1'b0);
        str_buf = '{8'h82, 8'hAC};
        send_string(OP_REPLACEMENT, 1'b1);
    endtask

    // Register extremes, no-change positions and a position past the end
    task automatic test_config_sweep();
        logic [63:0] starts[8];
        logic [63:0] spans[8];
        starts = '{64'h8000_0000_0000_0000, 64'd0, 64'd1, 64'd1,
                   64'd3, 64'h7FFF_FFFF_FFFF_FFFF, 64'd40, 64'd2};
        spans  = '{'1, 64'd5, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'd1, 64'd2, '1};
        for (int k = 0; k < 8; k++) begin
            wait_results_done();
            program_splice(starts[k], spans[k]);
            run_job(1'b0);
            run_job(1'b0);
        end
    endtask

    // Mostly well-formed jobs; settings change every few jobs
    task automatic test_random_jobs(input int budget);
        int first_item;
        int jobs;
        first_item = items_sent;
        jobs = 0;
        while (items_sent - first_item < budget) begin
            if (jobs % 4 == 3) begin
                wait_results_done();
                program_splice(pick_start(), pick_span());
            end
            run_job($urandom_range(4) == 0);
            jobs++;
        end
    endtask

    // Receiver holds off while items keep coming, then the sender waits for all results
    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (64) @(posedge aclk);
                hold_rx = 1'b0;
            end
        join_none
        run_job(1'b0);
        run_job(1'b0);
        run_job(1'b0);
        wait_results_done();
    endtask

    // Test sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_gap_pct    = 9;
        sink_stall_pct = 69;
        test_valid_chars();
        test_malformed();
        test_random_jobs(300);
        wait_results_done();

        src_gap_pct    = 69;
        sink_stall_pct = 9;
        test_config_sweep();
        test_random_jobs(200);
        wait_results_done();

        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_backpressure();
        test_random_jobs(100);

        wait_results_done();
        repeat (4) @(posedge aclk);
        if (pending_marks.size() != 0)
            report_mismatch("missing items", 32'(pending_marks.size()), 32'd0);
        if (mismatch_cnt == 0)
            $display("utf8_validating_string_splice_top_tb: clean");
        else
            $display("utf8_validating_string_splice_top_tb: errors");
        $finish;
    end

endmodule

### sim.f
rtl/u8splice_pkg.sv
rtl/utf8_validating_string_splice_top.sv
rtl/u8splice_checker.sv
tb/utf8_validating_string_splice_top_tb.sv
